/* sv/ptw_pkg.sv */
// Package for the three-level page table walker: config layout, codes, types.
// No dependencies; every other file of the walker uses it by scoped names.
`default_nettype none

package ptw_pkg;

  // Region register sets and how many of them the bound check may use
  localparam int unsigned REG_SETS     = 2;
  localparam int unsigned REGION_SLOTS = 2;

  localparam int unsigned PA_W   = 48;
  localparam int unsigned VA_W   = 39;
  localparam int unsigned SIZE_W = 49;
  localparam int unsigned CFG_W  = 49;
  localparam int unsigned IDX_W  = 3;

  // Config register indexes
  localparam logic [IDX_W-1:0] CFG_ENABLE    = 3'd0;
  localparam logic [IDX_W-1:0] CFG_ROOT_BASE = 3'd1;
  localparam logic [IDX_W-1:0] CFG_REG_COUNT = 3'd2;
  localparam logic [IDX_W-1:0] CFG_R0_BASE   = 3'd3;
  localparam logic [IDX_W-1:0] CFG_R0_SIZE   = 3'd4;
  localparam logic [IDX_W-1:0] CFG_R1_BASE   = 3'd5;
  localparam logic [IDX_W-1:0] CFG_R1_SIZE   = 3'd6;

  // Input function codes
  localparam logic FUNC_XLATE = 1'b0;
  localparam logic FUNC_DATA  = 1'b1;

  // Result kind codes
  localparam logic KIND_READ   = 1'b0;
  localparam logic KIND_RESULT = 1'b1;

  // Descriptor type codes
  localparam logic [1:0] DESC_BLOCK = 2'd1;
  localparam logic [1:0] DESC_TABLE = 2'd3;

  // Walk level: idle or waiting for that level's descriptor
  typedef enum logic [1:0] {
    LVL_IDLE = 2'd0,
    LVL_1    = 2'd1,
    LVL_2    = 2'd2,
    LVL_3    = 2'd3
  } level_e;

  typedef struct packed {
    logic                              enable;
    logic [PA_W-1:0]                   root_base;
    logic [1:0]                        region_count;
    logic [REG_SETS-1:0][PA_W-1:0]     reg_base;
    logic [REG_SETS-1:0][SIZE_W-1:0]   reg_size;
  } cfg_t;

  typedef struct packed {
    logic            kind;
    logic [PA_W-1:0] read_addr;
    logic [PA_W-1:0] xlat_addr;
    logic            ok;
  } res_t;

endpackage

`default_nettype wire

/* sv/ptw_cfg.sv */
// Configuration register file of the page table walker.
// Depends on ptw_pkg for register indexes and the cfg_t layout.
`default_nettype none

module ptw_cfg (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [ptw_pkg::IDX_W-1:0]  cfg_addr_i,
  input  wire logic [ptw_pkg::CFG_W-1:0]  cfg_wdata_i,
  output ptw_pkg::cfg_t                   cfg_o
);

  ptw_pkg::cfg_t cfg_q, cfg_d;

  // Write decode; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        ptw_pkg::CFG_ENABLE:    cfg_d.enable       = cfg_wdata_i[0];
        ptw_pkg::CFG_ROOT_BASE: cfg_d.root_base    = cfg_wdata_i[ptw_pkg::PA_W-1:0];
        ptw_pkg::CFG_REG_COUNT: cfg_d.region_count = cfg_wdata_i[1:0];
        ptw_pkg::CFG_R0_BASE:   cfg_d.reg_base[0]  = cfg_wdata_i[ptw_pkg::PA_W-1:0];
        ptw_pkg::CFG_R0_SIZE:   cfg_d.reg_size[0]  = cfg_wdata_i[ptw_pkg::SIZE_W-1:0];
        ptw_pkg::CFG_R1_BASE:   cfg_d.reg_base[1]  = cfg_wdata_i[ptw_pkg::PA_W-1:0];
        ptw_pkg::CFG_R1_SIZE:   cfg_d.reg_size[1]  = cfg_wdata_i[ptw_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* sv/ptw_region_chk.sv */
// DRAM region bound check: all 8 bytes of a descriptor inside one valid region.
// Depends on ptw_pkg for the region register layout.
`default_nettype none

module ptw_region_chk (
  input  wire logic [ptw_pkg::PA_W-1:0] addr_i,
  input  wire ptw_pkg::cfg_t            cfg_i,
  output logic                          hit_o
);

  logic [ptw_pkg::PA_W:0]   last;
  logic [ptw_pkg::REG_SETS-1:0] hit;

  // Last byte of the descriptor, one bit wider so it cannot wrap
  assign last = {1'b0, addr_i} + (ptw_pkg::PA_W+1)'(7);

  always_comb begin
    logic [ptw_pkg::PA_W+1:0] lim;
    for (int i = 0; i < ptw_pkg::REG_SETS; i++) begin
      lim    = {2'b00, cfg_i.reg_base[i]} + {1'b0, cfg_i.reg_size[i]};
      hit[i] = (2'(i) < cfg_i.region_count) && (i < ptw_pkg::REGION_SLOTS) &&
               (cfg_i.reg_size[i] != '0) && (cfg_i.reg_base[i] <= addr_i) &&
               ({1'b0, last} < lim);
    end
  end

  assign hit_o = |hit;

endmodule

`default_nettype wire

/* sv/ptw_walk.sv */
// Walk state machine: level and pending VA, plus the per-beat result logic.
// Depends on ptw_pkg and ptw_region_chk.
`default_nettype none

module ptw_walk (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        step_i,
  input  wire logic                        func_i,
  input  wire logic [ptw_pkg::VA_W-1:0]    va_i,
  input  wire logic [63:0]                 data_i,
  input  wire ptw_pkg::cfg_t               cfg_i,
  output ptw_pkg::res_t                    res_o
);

  ptw_pkg::level_e               lvl_q, lvl_d;
  logic [ptw_pkg::VA_W-1:0]      va_q, va_d;

  logic                          do_issue, do_fin;
  ptw_pkg::level_e               iss_lvl;
  logic [ptw_pkg::VA_W-1:0]      iss_va;
  logic [35:0]                   iss_table;
  logic [8:0]                    iss_idx;
  logic [ptw_pkg::PA_W-1:0]      iss_addr;
  logic [ptw_pkg::PA_W-1:0]      fin_pa;
  logic                          in_dram;
  logic [1:0]                    dtype;

  assign dtype = data_i[1:0];

  // Table index for the level being issued
  always_comb begin
    case (iss_lvl)
      ptw_pkg::LVL_1: iss_idx = iss_va[38:30];
      ptw_pkg::LVL_2: iss_idx = iss_va[29:21];
      default:        iss_idx = iss_va[20:12];
    endcase
  end

  assign iss_addr = {iss_table, iss_idx, 3'b000};

  ptw_region_chk u_region_chk (
    .addr_i (iss_addr),
    .cfg_i  (cfg_i),
    .hit_o  (in_dram)
  );

  // Next state and result
  always_comb begin
    lvl_d     = lvl_q;
    va_d      = va_q;
    do_issue  = 1'b0;
    do_fin    = 1'b0;
    iss_lvl   = ptw_pkg::LVL_1;
    iss_va    = va_q;
    iss_table = cfg_i.root_base[47:12];
    fin_pa    = '0;
    res_o     = '{kind: ptw_pkg::KIND_RESULT, read_addr: '0, xlat_addr: '0, ok: 1'b0};

    if (func_i == ptw_pkg::FUNC_XLATE) begin
      // New request: faults when busy or disabled, state untouched
      if (lvl_q == ptw_pkg::LVL_IDLE && cfg_i.enable) begin
        va_d     = va_i;
        iss_va   = va_i;
        do_issue = 1'b1;
      end
    end else begin
      unique case (lvl_q)
        ptw_pkg::LVL_IDLE: ;
        ptw_pkg::LVL_3: begin
          if (dtype == ptw_pkg::DESC_TABLE) begin
            do_fin = 1'b1;
            fin_pa = {data_i[47:12], va_q[11:0]};
          end else begin
            lvl_d = ptw_pkg::LVL_IDLE;
          end
        end
        ptw_pkg::LVL_1, ptw_pkg::LVL_2: begin
          if (dtype == ptw_pkg::DESC_BLOCK) begin
            do_fin = 1'b1;
            fin_pa = (lvl_q == ptw_pkg::LVL_1) ? {data_i[47:30], va_q[29:0]}
                                               : {data_i[47:21], va_q[20:0]};
          end else if (dtype == ptw_pkg::DESC_TABLE) begin
            do_issue  = 1'b1;
            iss_table = data_i[47:12];
            iss_lvl   = (lvl_q == ptw_pkg::LVL_1) ? ptw_pkg::LVL_2 : ptw_pkg::LVL_3;
          end else begin
            lvl_d = ptw_pkg::LVL_IDLE;
          end
        end
      endcase
    end

    // Descriptor read, if the address passes the bound check
    if (do_issue) begin
      if (in_dram) begin
        lvl_d           = iss_lvl;
        res_o.kind      = ptw_pkg::KIND_READ;
        res_o.read_addr = iss_addr;
      end else begin
        lvl_d = ptw_pkg::LVL_IDLE;
      end
    end

    // Walk done; a zero page address counts as a fault
    if (do_fin) begin
      lvl_d = ptw_pkg::LVL_IDLE;
      if (fin_pa[47:12] != '0) begin
        res_o.xlat_addr = fin_pa;
        res_o.ok        = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q <= ptw_pkg::LVL_IDLE;
    end else if (step_i) begin
      lvl_q <= lvl_d;
    end
  end

  // Pending VA is payload, no reset
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      va_q <= va_d;
    end
  end

endmodule

`default_nettype wire

/* sv/three_level_page_table_walker.sv */
// Three-level page table walker, 4 KB granule, 39-bit VA. A translate request
// (func 0) yields one beat out: either a descriptor read address (kind 0) or a
// fault; each returned descriptor (func 1) yields the next read, the final
// translation or a fault (kind 1). Throughput is one beat per cycle when the
// output is not stalled. A beat passes through an input register, then the walk
// logic and region bound check in one step into the result register. Walk
// state updates when a beat leaves the input register, so back-to-back beats
// see the state left by the previous one. Write config only while no beat is
// in flight.
// Depends on ptw_pkg, ptw_cfg, ptw_walk and ptw_region_chk.
`default_nettype none

module three_level_page_table_walker (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // config write port
  input  wire logic                        cfg_we_i,
  input  wire logic [ptw_pkg::IDX_W-1:0]   cfg_addr_i,
  input  wire logic [ptw_pkg::CFG_W-1:0]   cfg_wdata_i,
  // input channel
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic                        in_func_i,
  input  wire logic [ptw_pkg::VA_W-1:0]    in_virt_addr_i,
  input  wire logic [63:0]                 in_read_data_i,
  // output channel
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic                             out_kind_o,
  output logic [ptw_pkg::PA_W-1:0]         out_read_addr_o,
  output logic [ptw_pkg::PA_W-1:0]         out_xlat_addr_o,
  output logic                             out_ok_o
);

  ptw_pkg::cfg_t               cfg;
  ptw_pkg::res_t               res, res_q;

  logic                        s1_valid_q, s1_valid_d;
  logic                        s1_func_q;
  logic [ptw_pkg::VA_W-1:0]    s1_va_q;
  logic [63:0]                 s1_data_q;
  logic                        out_valid_q, out_valid_d;
  logic                        advance, in_acc;

  ptw_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Handshake: stage 1 moves on when the result register is free or draining
  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_func_q <= in_func_i;
      s1_va_q   <= in_virt_addr_i;
      s1_data_q <= in_read_data_i;
    end
  end

  ptw_walk u_walk (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .func_i (s1_func_q),
    .va_i   (s1_va_q),
    .data_i (s1_data_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Result register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_kind_o      = res_q.kind;
  assign out_read_addr_o = res_q.read_addr;
  assign out_xlat_addr_o = res_q.xlat_addr;
  assign out_ok_o        = res_q.ok;

endmodule

`default_nettype wire
